>>> sv/arvi_pkg.sv
// ----------------------------------------------------------------------------
// arvi_pkg: shared types and constants for the aim-relative velocity impulse
// Fixed-point formats, payload structs, register indexes and the rounding and
// saturation helpers of the top level; the normalizer takes FRAC_BITS from here.
// ----------------------------------------------------------------------------
package arvi_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   // A unit-length component needs the value one plus a sign bit.
   localparam int UNIT_BITS = FRAC_BITS + 2;

   localparam logic signed [UNIT_BITS-1:0] ONE_UNIT =
      UNIT_BITS'(64'd1 << FRAC_BITS);
   localparam logic signed [UNIT_BITS-1:0] NEAR_ONE =
      UNIT_BITS'((64'd9999 << FRAC_BITS) / 64'd10000);
   localparam longint unsigned SMALL_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;
   localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);
   localparam logic signed [63:0] WORD_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] WORD_MIN = -WORD_MAX - 64'sd1;

   localparam logic [1:0] MODE_ABSOLUTE = 2'd1;

   typedef enum logic [2:0] {
      REG_LAUNCH_MODE     = 3'd0,
      REG_IGNORE_VERTICAL = 3'd1,
      REG_ABSOLUTE_X      = 3'd2,
      REG_ABSOLUTE_Y      = 3'd3,
      REG_ABSOLUTE_Z      = 3'd4,
      REG_OFFSET_FORWARD  = 3'd5,
      REG_OFFSET_RIGHT    = 3'd6,
      REG_OFFSET_UP       = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] aim_x;
      logic signed [WORD_BITS-1:0] aim_y;
      logic signed [WORD_BITS-1:0] aim_z;
      logic signed [WORD_BITS-1:0] vel_x;
      logic signed [WORD_BITS-1:0] vel_y;
      logic signed [WORD_BITS-1:0] vel_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] new_vel_x;
      logic signed [WORD_BITS-1:0] new_vel_y;
      logic signed [WORD_BITS-1:0] new_vel_z;
      logic signed [WORD_BITS-1:0] impulse_x;
      logic signed [WORD_BITS-1:0] impulse_y;
      logic signed [WORD_BITS-1:0] impulse_z;
   } rsp_payload_type;

   // Drops FRAC_BITS fraction bits, rounding to nearest with ties away from zero.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v);
      logic [63:0] m;
      logic [63:0] r;
      m = v[63] ? 64'(-v) : 64'(v);
      r = (m + HALF_LSB) >> FRAC_BITS;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [63:0] v);
      if (v > WORD_MAX) begin
         return WORD_BITS'(WORD_MAX);
      end else if (v < WORD_MIN) begin
         return WORD_BITS'(WORD_MIN);
      end
      return WORD_BITS'(v);
   endfunction

endpackage

>>> sv/arvi_norm.sv
// ----------------------------------------------------------------------------
// arvi_norm: pipelined three-component vector normalizer
// Squares and sums the components, takes a bit-per-stage integer square root
// and divides each component by the length with a bit-per-stage divider.
// Vectors whose squared length is not above LIMIT, or whose allow bit is low,
// leave unchanged.
// ----------------------------------------------------------------------------
module arvi_norm import arvi_pkg::*; #(
   parameter int CW = 18,
   parameter int SW = 1,
   parameter longint unsigned LIMIT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic                  in_allow,
   input  logic [2:0][CW-1:0]    in_x,
   input  logic [SW-1:0]         in_side,
   output logic                  out_valid,
   output logic [2:0][CW-1:0]    out_x,
   output logic [SW-1:0]         out_side
);

   localparam int SQW = 2 * CW + 2;
   localparam int NS  = CW + 1;
   localparam int ND  = FRAC_BITS + 1;
   localparam int NW  = CW + FRAC_BITS + 2;
   localparam int T   = NS + ND + 3;

   logic [T-1:0]           vld_ff;
   logic [T-1:0]           flag_ff;
   logic [2:0][CW-1:0]     x_ff    [T];
   logic [SW-1:0]          side_ff [T];

   logic [2:0][CW-1:0]     mag_a;
   logic [2:0][2*CW-1:0]   sqa_in, sqa_ff;
   logic [SQW-1:0]         sq_sum;
   logic                   do_in;
   logic [SQW-1:0]         rem_in  [NS+1];
   logic [SQW-1:0]         rem_ff  [NS+1];
   logic [SQW-1:0]         root_in [NS+1];
   logic [SQW-1:0]         root_ff [NS+1];
   logic [SQW-1:0]         trial   [NS];
   logic [NS-1:0]          len_c;
   logic [2:0][CW-1:0]     mag_c;
   logic [2:0][NW-1:0]     num_in  [ND+1];
   logic [2:0][NW-1:0]     num_ff  [ND+1];
   logic [NS-1:0]          d_in    [ND+1];
   logic [NS-1:0]          d_ff    [ND+1];
   logic [2:0][ND-1:0]     q_in    [ND+1];
   logic [2:0][ND-1:0]     q_ff    [ND+1];
   logic [NW-1:0]          dsh     [ND];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_a[i]  = in_x[i][CW-1] ? -in_x[i] : in_x[i];
         sqa_in[i] = (2*CW)'(mag_a[i]) * (2*CW)'(mag_a[i]);
      end
      sq_sum = SQW'(sqa_ff[0]) + SQW'(sqa_ff[1]) + SQW'(sqa_ff[2]);
      do_in  = flag_ff[0] && (sq_sum > SQW'(LIMIT));

      // Square root, one result bit per stage.
      rem_in[0]  = sq_sum;
      root_in[0] = '0;
      for (int k = 0; k < NS; k++) begin
         trial[k] = root_ff[k] + (SQW'(1) << (2 * (NS - 1 - k)));
         if (rem_ff[k] >= trial[k]) begin
            rem_in[k+1]  = rem_ff[k] - trial[k];
            root_in[k+1] = (root_ff[k] >> 1) + (SQW'(1) << (2 * (NS - 1 - k)));
         end else begin
            rem_in[k+1]  = rem_ff[k];
            root_in[k+1] = root_ff[k] >> 1;
         end
      end

      // Rounded quotient: the numerator is below twice the length times 2^F.
      len_c = root_ff[NS][NS-1:0];
      for (int i = 0; i < 3; i++) begin
         mag_c[i]     = x_ff[NS+1][i][CW-1] ? -x_ff[NS+1][i] : x_ff[NS+1][i];
         num_in[0][i] = (NW'(mag_c[i]) << FRAC_BITS) + NW'(len_c >> 1);
      end
      d_in[0] = len_c;
      q_in[0] = '0;
      for (int j = 0; j < ND; j++) begin
         dsh[j]    = NW'(d_ff[j]) << (ND - 1 - j);
         d_in[j+1] = d_ff[j];
         for (int i = 0; i < 3; i++) begin
            if (num_ff[j][i] >= dsh[j]) begin
               num_in[j+1][i] = num_ff[j][i] - dsh[j];
               q_in[j+1][i]   = q_ff[j][i] | (ND'(1) << (ND - 1 - j));
            end else begin
               num_in[j+1][i] = num_ff[j][i];
               q_in[j+1][i]   = q_ff[j][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[T-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= in_x;
         side_ff[0] <= in_side;
         flag_ff[0] <= in_allow;
         flag_ff[1] <= do_in;
         for (int s = 1; s < T; s++) begin
            x_ff[s]    <= x_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 2; s < T; s++) begin
            flag_ff[s] <= flag_ff[s-1];
         end
         sqa_ff <= sqa_in;
         for (int k = 0; k <= NS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         for (int j = 0; j <= ND; j++) begin
            num_ff[j] <= num_in[j];
            d_ff[j]   <= d_in[j];
            q_ff[j]   <= q_in[j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (flag_ff[T-1]) begin
            out_x[i] = x_ff[T-1][i][CW-1] ? -CW'(q_ff[ND][i]) : CW'(q_ff[ND][i]);
         end else begin
            out_x[i] = x_ff[T-1][i];
         end
      end
   end

   assign out_valid = vld_ff[T-1];
   assign out_side  = side_ff[T-1];

endmodule

>>> sv/aim_relative_velocity_impulse_top.sv
// ----------------------------------------------------------------------------
// aim_relative_velocity_impulse_top: velocity impulse from an aim direction
// Builds a forward/right/up basis from the aim, maps a local offset through
// it (or takes a fixed world vector) and adds the impulse to the velocity.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the output buffer has room
// and returns one result per transaction, in order. Most of the pipeline depth lies
// in the four normalizer pipelines, each of which spends one stage per square-root
// bit and one stage per quotient bit, so the 66-bit squared length of the raw aim
// costs the most. Every stage advances together; a two-entry output buffer keeps the
// input open while one finished result waits to be taken. Registers are written
// through the APB-style port and must only change while no transaction is in
// flight.
module aim_relative_velocity_impulse_top import arvi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [4:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   localparam int U  = UNIT_BITS;
   localparam int UP = UNIT_BITS + 2;
   localparam int VW = 3 * WORD_BITS;
   localparam int MW = UP + WORD_BITS;

   // Configuration registers.
   logic [1:0]                  launch_mode_ff;
   logic                        ignore_ff;
   logic signed [WORD_BITS-1:0] abs_ff [3];
   logic signed [WORD_BITS-1:0] off_ff [3];
   reg_index_type               reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_mode_ff <= 2'd2;
         ignore_ff      <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            abs_ff[i] <= '0;
            off_ff[i] <= '0;
         end
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_LAUNCH_MODE:     launch_mode_ff <= pwdata[1:0];
            REG_IGNORE_VERTICAL: ignore_ff      <= pwdata[0];
            REG_ABSOLUTE_X:      abs_ff[0]      <= pwdata;
            REG_ABSOLUTE_Y:      abs_ff[1]      <= pwdata;
            REG_ABSOLUTE_Z:      abs_ff[2]      <= pwdata;
            REG_OFFSET_FORWARD:  off_ff[0]      <= pwdata;
            REG_OFFSET_RIGHT:    off_ff[1]      <= pwdata;
            REG_OFFSET_UP:       off_ff[2]      <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LAUNCH_MODE:     prdata = 32'(launch_mode_ff);
         REG_IGNORE_VERTICAL: prdata = 32'(ignore_ff);
         REG_ABSOLUTE_X:      prdata = abs_ff[0];
         REG_ABSOLUTE_Y:      prdata = abs_ff[1];
         REG_ABSOLUTE_Z:      prdata = abs_ff[2];
         REG_OFFSET_FORWARD:  prdata = off_ff[0];
         REG_OFFSET_RIGHT:    prdata = off_ff[1];
         REG_OFFSET_UP:       prdata = off_ff[2];
         default:             prdata = '0;
      endcase
   end

   // The whole pipeline moves while the output buffer has room.
   logic en;
   logic skid_vld_ff, out_vld_ff;

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   // Forward axis: normalize the raw aim.
   logic [2:0][WORD_BITS-1:0] n1_in, n1_x;
   logic [VW-1:0]             n1_side;
   logic                      n1_vld;

   assign n1_in[0] = req_payload.aim_x;
   assign n1_in[1] = req_payload.aim_y;
   assign n1_in[2] = req_payload.aim_z;

   arvi_norm #(.CW(WORD_BITS), .SW(VW), .LIMIT(SMALL_SQ)) u_norm_fwd (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_allow(1'b1), .in_x(n1_in),
      .in_side({req_payload.vel_z, req_payload.vel_y, req_payload.vel_x}),
      .out_valid(n1_vld), .out_x(n1_x), .out_side(n1_side)
   );

   // A normalized component never exceeds one, and a vector too short to be
   // normalized has tiny components, so the unit width holds either case.
   logic [2:0][U-1:0] n2_in, n2_x;
   logic [VW-1:0]     n2_side;
   logic              n2_vld;

   assign n2_in[0] = n1_x[0][U-1:0];
   assign n2_in[1] = n1_x[1][U-1:0];
   assign n2_in[2] = ignore_ff ? '0 : n1_x[2][U-1:0];

   // Flattening pass; when flattening is off the vector passes unchanged.
   arvi_norm #(.CW(U), .SW(VW), .LIMIT(SMALL_SQ)) u_norm_flat (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(n1_vld), .in_allow(ignore_ff), .in_x(n2_in), .in_side(n1_side),
      .out_valid(n2_vld), .out_x(n2_x), .out_side(n2_side)
   );

   // Right axis is forward cross world up, or unit X when aiming nearly
   // straight up or down.
   logic              near_vert;
   logic [2:0][U-1:0] n3_in, n3_x;
   logic [VW+3*U-1:0] n3_side;
   logic              n3_vld;

   assign near_vert = ($signed(n2_x[2]) > NEAR_ONE) || ($signed(n2_x[2]) < -NEAR_ONE);
   assign n3_in[0]  = near_vert ? ONE_UNIT : n2_x[1];
   assign n3_in[1]  = near_vert ? '0 : -n2_x[0];
   assign n3_in[2]  = '0;

   arvi_norm #(.CW(U), .SW(VW + 3 * U), .LIMIT(0)) u_norm_right (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(n2_vld), .in_allow(1'b1), .in_x(n3_in), .in_side({n2_x, n2_side}),
      .out_valid(n3_vld), .out_x(n3_x), .out_side(n3_side)
   );

   // Up axis is right cross forward; right has no z component.
   logic [2:0][U-1:0]    fw3;
   logic signed [2*U-1:0] p_in [4];
   logic signed [2*U-1:0] p_ff [4];
   logic [VW+6*U-1:0]    p_side_ff, q_side_ff;
   logic                 p_vld_ff, q_vld_ff;
   logic [2:0][UP-1:0]   up_in, up_ff;

   assign fw3 = n3_side[VW+3*U-1:VW];

   always_comb begin
      p_in[0] = $signed(n3_x[1]) * $signed(fw3[2]);
      p_in[1] = $signed(n3_x[0]) * $signed(fw3[2]);
      p_in[2] = $signed(n3_x[0]) * $signed(fw3[1]);
      p_in[3] = $signed(n3_x[1]) * $signed(fw3[0]);
      up_in[0] = UP'(round_shift(64'(p_ff[0])));
      up_in[1] = UP'(-round_shift(64'(p_ff[1])));
      up_in[2] = UP'(round_shift(64'(p_ff[2]) - 64'(p_ff[3])));
   end

   logic [2:0][UP-1:0]   n4_x;
   logic [VW+6*U-1:0]    n4_side;
   logic                 n4_vld;

   arvi_norm #(.CW(UP), .SW(VW + 6 * U), .LIMIT(0)) u_norm_up (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(q_vld_ff), .in_allow(1'b1), .in_x(up_ff), .in_side(q_side_ff),
      .out_valid(n4_vld), .out_x(n4_x), .out_side(n4_side)
   );

   // Map the local offset through the basis.
   logic [2:0][U-1:0]          rt4, fw4;
   logic [VW-1:0]              vel4;
   logic signed [MW-1:0]       mf_in [3], mr_in [3], mu_in [3];
   logic signed [MW-1:0]       mf_ff [3], mr_ff [3], mu_ff [3];
   logic [VW-1:0]              m_vel_ff;
   logic                       m_vld_ff;

   assign rt4  = n4_side[VW+6*U-1:VW+3*U];
   assign fw4  = n4_side[VW+3*U-1:VW];
   assign vel4 = n4_side[VW-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mf_in[i] = $signed(fw4[i]) * off_ff[0];
         mr_in[i] = $signed(rt4[i]) * off_ff[1];
         mu_in[i] = $signed(n4_x[i]) * off_ff[2];
      end
   end

   logic signed [WORD_BITS-1:0] imp_in [3];
   logic signed [WORD_BITS-1:0] s_imp_ff [3];
   logic [VW-1:0]               s_vel_ff;
   logic                        s_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (launch_mode_ff == MODE_ABSOLUTE) begin
            imp_in[i] = abs_ff[i];
         end else begin
            imp_in[i] = sat_word(round_shift(64'(mf_ff[i]) + 64'(mr_ff[i])
                                             + 64'(mu_ff[i])));
         end
      end
   end

   rsp_payload_type fin_in, fin_ff;
   logic            fin_vld_ff;

   always_comb begin
      fin_in.impulse_x = s_imp_ff[0];
      fin_in.impulse_y = s_imp_ff[1];
      fin_in.impulse_z = s_imp_ff[2];
      fin_in.new_vel_x = sat_word(64'($signed(s_vel_ff[WORD_BITS-1:0]))
                                  + 64'(s_imp_ff[0]));
      fin_in.new_vel_y = sat_word(64'($signed(s_vel_ff[2*WORD_BITS-1:WORD_BITS]))
                                  + 64'(s_imp_ff[1]));
      fin_in.new_vel_z = sat_word(64'($signed(s_vel_ff[VW-1:2*WORD_BITS]))
                                  + 64'(s_imp_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff   <= 1'b0;
         q_vld_ff   <= 1'b0;
         m_vld_ff   <= 1'b0;
         s_vld_ff   <= 1'b0;
         fin_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff   <= n3_vld;
         q_vld_ff   <= p_vld_ff;
         m_vld_ff   <= n4_vld;
         s_vld_ff   <= m_vld_ff;
         fin_vld_ff <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff      <= p_in;
         p_side_ff <= {n3_x, n3_side};
         up_ff     <= up_in;
         q_side_ff <= p_side_ff;
         mf_ff     <= mf_in;
         mr_ff     <= mr_in;
         mu_ff     <= mu_in;
         m_vel_ff  <= vel4;
         s_imp_ff  <= imp_in;
         s_vel_ff  <= m_vel_ff;
         fin_ff    <= fin_in;
      end
   end

   // Output register with one skid entry behind it.
   rsp_payload_type out_in, out_ff, skid_in, skid_ff;
   logic            out_vld_in, skid_vld_in;

   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (out_vld_ff && !rsp_ready) begin
         if (en && fin_vld_ff) begin
            skid_in     = fin_ff;
            skid_vld_in = 1'b1;
         end
      end else if (skid_vld_ff) begin
         out_in      = skid_ff;
         out_vld_in  = 1'b1;
         skid_vld_in = 1'b0;
      end else begin
         out_in     = fin_ff;
         out_vld_in = en && fin_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   // The skid entry is only ever filled behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry holds a result while the output is empty");

   // Once the waiting result is taken the skid entry is empty on the following clock.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && rsp_ready |=> !skid_vld_ff)
      else $error("skid entry did not drain");

   // The forward axis never grows beyond unit length per component.
   a_forward_bounded: assert property (@(posedge clock) disable iff (reset)
      n2_vld |-> ($signed(n2_x[0]) <= ONE_UNIT && $signed(n2_x[0]) >= -ONE_UNIT &&
                  $signed(n2_x[1]) <= ONE_UNIT && $signed(n2_x[1]) >= -ONE_UNIT &&
                  $signed(n2_x[2]) <= ONE_UNIT && $signed(n2_x[2]) >= -ONE_UNIT))
      else $error("forward axis component out of unit range");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for aim_relative_velocity_impulse_top
// Streams aim and velocity transactions through the block under random
// idling and long back-pressure, predicts every result in fixed point and
// compares each one field by field, over several register settings.
// ----------------------------------------------------------------------------
module testbench import arvi_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   typedef longint vec3_type [3];

   // Thresholds of the relative-mode basis, in raw Q16.16 units (the squared floor in Q32.32).
   localparam longint unsigned AIM_FLOOR_SQ   = (64'd1 << 32) / 64'd10000;
   localparam longint          VERTICAL_LIMIT = 65529;
   localparam longint          UNIT_RAW       = 65536;
   // This drain margin covers the depth of the pipeline comfortably.
   localparam int              DRAIN_CYCLES   = 300;
   localparam int              LONG_HOLD      = 500;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [4:0]      paddr;
   logic [31:0]     pwdata;
   logic [31:0]     prdata;
   logic            pready;

   aim_relative_velocity_impulse_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow copy of the register file, updated whenever a register is written.
   logic [1:0]         launch_mode_copy;
   logic               flatten_copy;
   logic signed [31:0] world_impulse [3];
   logic signed [31:0] local_offset  [3];

   req_payload_type pending_aims [$];
   rsp_payload_type expected_velocities [$];
   int              mismatch_count = 0;
   bit              quiet_phase;
   int              hold_requests;

   // --------------------------------------------------------------------------
   // Fixed-point model of the impulse computation.
   // --------------------------------------------------------------------------
   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Scales v to unit length unless its squared length is at most limit.
   function automatic vec3_type unit_vector(vec3_type v, longint unsigned limit);
      longint unsigned sq;
      longint unsigned len;
      longint unsigned q;
      vec3_type r;
      sq = 0;
      r = v;
      for (int i = 0; i < 3; i++) sq += magnitude(v[i]) * magnitude(v[i]);
      if (sq <= limit) return v;
      len = floor_sqrt(sq);
      if (len == 0) return v;
      for (int i = 0; i < 3; i++) begin
         q = ((magnitude(v[i]) << 16) + (len >> 1)) / len;
         r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return r;
   endfunction

   function automatic longint drop_fraction(longint v);
      longint unsigned m;
      m = (magnitude(v) + 64'd32768) >> 16;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [31:0] clamp_word(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic rsp_payload_type launch_velocity(req_payload_type p);
      vec3_type        fw;
      vec3_type        rt;
      vec3_type        up;
      vec3_type        vel;
      longint          imp [3];
      rsp_payload_type r;
      fw  = '{longint'(p.aim_x), longint'(p.aim_y), longint'(p.aim_z)};
      vel = '{longint'(p.vel_x), longint'(p.vel_y), longint'(p.vel_z)};
      if (launch_mode_copy == MODE_ABSOLUTE) begin
         for (int i = 0; i < 3; i++) imp[i] = longint'(world_impulse[i]);
      end else begin
         fw = unit_vector(fw, AIM_FLOOR_SQ);
         if (flatten_copy) begin
            fw[2] = 0;
            fw = unit_vector(fw, AIM_FLOOR_SQ);
         end
         if (fw[2] > VERTICAL_LIMIT || fw[2] < -VERTICAL_LIMIT) begin
            rt = '{UNIT_RAW, 0, 0};
         end else begin
            rt = '{fw[1], -fw[0], 0};
         end
         rt = unit_vector(rt, 0);
         up[0] = drop_fraction(rt[1] * fw[2] - rt[2] * fw[1]);
         up[1] = drop_fraction(rt[2] * fw[0] - rt[0] * fw[2]);
         up[2] = drop_fraction(rt[0] * fw[1] - rt[1] * fw[0]);
         up = unit_vector(up, 0);
         for (int i = 0; i < 3; i++) begin
            imp[i] = longint'(clamp_word(drop_fraction(
               fw[i] * longint'(local_offset[0]) + rt[i] * longint'(local_offset[1])
               + up[i] * longint'(local_offset[2]))));
         end
      end
      r.new_vel_x = clamp_word(vel[0] + imp[0]);
      r.new_vel_y = clamp_word(vel[1] + imp[1]);
      r.new_vel_z = clamp_word(vel[2] + imp[2]);
      r.impulse_x = imp[0][31:0];
      r.impulse_y = imp[1][31:0];
      r.impulse_z = imp[2][31:0];
      return r;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
         mismatch_count++;
      end
   endfunction

   // --------------------------------------------------------------------------
   // Clock and reset. Reset is applied once, at the start of the run.
   // --------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // --------------------------------------------------------------------------
   // Driver: offers the queued transactions, with random idle bursts. Valid is
   // only lowered after a transaction has been accepted.
   // --------------------------------------------------------------------------
   int send_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         send_gap    <= 0;
      end else if (req_valid && !req_ready) begin
         // Hold the offered transaction until the block takes it.
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (pending_aims.size() > 0) begin
         if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            send_gap  <= $urandom_range(0, 7);
         end else begin
            req_payload <= pending_aims.pop_front();
            req_valid   <= 1'b1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // --------------------------------------------------------------------------
   // Receiver ready: random stall bursts, plus a long hold-off on request so
   // that the pipeline fills and the block pushes back on its input.
   // --------------------------------------------------------------------------
   int hold_count;
   int holds_served;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         hold_count   <= 0;
         holds_served <= 0;
      end else if (hold_count > 0) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count - 1;
      end else if (holds_served != hold_requests) begin
         rsp_ready    <= 1'b0;
         hold_count   <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         hold_count <= $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: predicts on every accepted input transaction and checks every
   // accepted result transaction against the oldest prediction.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) expected_velocities.push_back(launch_velocity(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_velocities.size() == 0) begin
               $error("result transaction arrived with no prediction pending");
               mismatch_count++;
            end else begin
               want = expected_velocities.pop_front();
               compare_field("new_vel_x", want.new_vel_x, rsp_payload.new_vel_x);
               compare_field("new_vel_y", want.new_vel_y, rsp_payload.new_vel_y);
               compare_field("new_vel_z", want.new_vel_z, rsp_payload.new_vel_z);
               compare_field("impulse_x", want.impulse_x, rsp_payload.impulse_x);
               compare_field("impulse_y", want.impulse_y, rsp_payload.impulse_y);
               compare_field("impulse_z", want.impulse_z, rsp_payload.impulse_z);
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers.
   // --------------------------------------------------------------------------
   // A setup phase, an access phase, then an idle phase on the bus.
   task automatic write_register(reg_index_type index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_LAUNCH_MODE:     launch_mode_copy = value[1:0];
         REG_IGNORE_VERTICAL: flatten_copy = value[0];
         REG_ABSOLUTE_X:      world_impulse[0] = value;
         REG_ABSOLUTE_Y:      world_impulse[1] = value;
         REG_ABSOLUTE_Z:      world_impulse[2] = value;
         REG_OFFSET_FORWARD:  local_offset[0] = value;
         REG_OFFSET_RIGHT:    local_offset[1] = value;
         REG_OFFSET_UP:       local_offset[2] = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Waits until every transaction has been taken and every result has come,
   // then lets the pipeline run empty.
   task automatic wait_for_idle();
      while (pending_aims.size() > 0 || req_valid || expected_velocities.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A word from a mix of extremes, small magnitudes and full-range values.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2, 3: return $urandom_range(0, 2 * 262144) - 262144;
         4: return $urandom_range(0, 2 * 2048) - 2048;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_payload_type random_aim();
      req_payload_type p;
      int kind;
      kind = $urandom_range(0, 9);
      p.aim_x = $urandom_range(0, 2 * 524288) - 524288;
      p.aim_y = $urandom_range(0, 2 * 524288) - 524288;
      p.aim_z = $urandom_range(0, 2 * 524288) - 524288;
      case (kind)
         0: begin
            p.aim_x = $urandom();
            p.aim_y = $urandom();
            p.aim_z = $urandom();
         end
         1: begin
            // Tiny aims around the small-length threshold.
            p.aim_x = $urandom_range(0, 1400) - 700;
            p.aim_y = $urandom_range(0, 1400) - 700;
            p.aim_z = $urandom_range(0, 1400) - 700;
         end
         2: begin
            // Close to straight up or down.
            p.aim_x = $urandom_range(0, 2000) - 1000;
            p.aim_y = $urandom_range(0, 2000) - 1000;
            p.aim_z = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
         end
         3: begin
            p.aim_x = 0;
            p.aim_y = 0;
            if ($urandom_range(0, 1)) p.aim_z = 0;
         end
         default: ;
      endcase
      p.vel_x = pick_word();
      p.vel_y = pick_word();
      p.vel_z = pick_word();
      return p;
   endfunction

   task automatic queue_aim(longint ax, longint ay, longint az, longint v);
      req_payload_type p;
      p.aim_x = ax[31:0];
      p.aim_y = ay[31:0];
      p.aim_z = az[31:0];
      p.vel_x = v[31:0];
      p.vel_y = v[31:0];
      p.vel_z = 32'(-v);
      pending_aims.push_back(p);
   endtask

   // Field extremes, both small-aim sides, zero aim, vertical and near-vertical
   // aims, pure horizontal aim and saturating velocities.
   task automatic queue_directed();
      queue_aim(0, 0, 0, 0);
      queue_aim(2147483647, 2147483647, 2147483647, 2147483647);
      queue_aim(-2147483648, -2147483648, -2147483648, -2147483648);
      queue_aim(2147483647, -2147483648, 0, 2147483647);
      queue_aim(655, 0, 0, 100);
      queue_aim(656, 0, 0, 100);
      queue_aim(0, -655, 0, 0);
      queue_aim(0, 0, 65536, 0);
      queue_aim(0, 0, -65536, 0);
      queue_aim(700, 0, 65529, 0);
      queue_aim(800, 0, 65529, 0);
      queue_aim(65536, 0, 0, 0);
      queue_aim(0, 65536, 10, -2147483648);
      queue_aim(46341, 46341, 0, 65536);
      queue_aim(100, 100, 1000000, 0);
      queue_aim(-12345678, 87654321, -555555, 2147483000);
      queue_aim(1, 1, 1, -2147483000);
      queue_aim(-1, -1, -1, 1);
   endtask

   // --------------------------------------------------------------------------
   // Main sequence: directed items, then random phases with fresh register
   // settings written while the block is idle.
   // --------------------------------------------------------------------------
   initial begin
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      quiet_phase      = 1'b0;
      hold_requests    = 0;
      launch_mode_copy = 2'd2;
      flatten_copy     = 1'b0;
      for (int i = 0; i < 3; i++) begin
         world_impulse[i] = '0;
         local_offset[i]  = '0;
      end
      @(negedge reset);
      @(posedge clock);

      // Reset settings first, then a relative setting with a modest offset.
      queue_directed();
      wait_for_idle();
      write_register(REG_OFFSET_FORWARD, 32'sd131072);
      write_register(REG_OFFSET_RIGHT, 32'sd65536);
      write_register(REG_OFFSET_UP, -32'sd32768);
      queue_directed();
      wait_for_idle();
      write_register(REG_IGNORE_VERTICAL, 32'd1);
      queue_directed();
      wait_for_idle();

      for (int phase = 0; phase < 8; phase++) begin
         logic [31:0] mode_word;
         // All four mode codes are used; extremes of every offset come up too.
         mode_word = {$urandom_range(0, 1) ? 30'h3fffffff : 30'h0, 2'(phase % 4)};
         write_register(REG_LAUNCH_MODE, mode_word);
         write_register(REG_IGNORE_VERTICAL, {31'($urandom()), phase[1]});
         if (phase == 6) begin
            write_register(REG_ABSOLUTE_X, 32'h7fffffff);
            write_register(REG_ABSOLUTE_Y, 32'h80000000);
            write_register(REG_ABSOLUTE_Z, 32'h7fffffff);
            write_register(REG_OFFSET_FORWARD, 32'h80000000);
            write_register(REG_OFFSET_RIGHT, 32'h7fffffff);
            write_register(REG_OFFSET_UP, 32'h80000000);
         end else begin
            write_register(REG_ABSOLUTE_X, pick_word());
            write_register(REG_ABSOLUTE_Y, pick_word());
            write_register(REG_ABSOLUTE_Z, pick_word());
            write_register(REG_OFFSET_FORWARD, pick_word());
            write_register(REG_OFFSET_RIGHT, pick_word());
            write_register(REG_OFFSET_UP, pick_word());
         end
         quiet_phase = (phase == 7);
         for (int n = 0; n < 190; n++) pending_aims.push_back(random_aim());
         // Mid-phase, the receiver holds off long enough to back up the input.
         if (phase == 2 || phase == 5) begin
            repeat (40) @(posedge clock);
            hold_requests++;
         end
         wait_for_idle();
      end

      if (mismatch_count == 0) begin
         $display("aim_relative_velocity_impulse_top regression: pass");
      end else begin
         $display("aim_relative_velocity_impulse_top regression: fail");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("aim_relative_velocity_impulse_top regression: fail");
      $finish;
   end

endmodule
